FILE: design/ncp_pkg.sv
package ncp_pkg;

  localparam int unsigned DEPTH_W   = 31;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  localparam int unsigned MUL_W     = 64;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MUL_STEPS = MUL_W / DIGIT_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

  localparam int unsigned NUM_W     = 80;
  localparam int unsigned DIV_STEPS = DEPTH_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        [31:0] entity_id;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic        [30:0] height;
    logic        [30:0] sel_radius;
    logic        [30:0] model_scale;
    logic               last_entity;
  } cand_t;

  typedef struct packed {
    logic               hit_found;
    logic        [31:0] best_id;
    logic        [30:0] best_depth;
  } pick_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } reg_idx_t;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_A1   = 16'h0002,
    ST_A2   = 16'h0004,
    ST_M1   = 16'h0008,
    ST_M2   = 16'h0010,
    ST_BM   = 16'h0020,
    ST_DIV1 = 16'h0040,
    ST_ZM   = 16'h0080,
    ST_ZCMP = 16'h0100,
    ST_ZDIV = 16'h0200,
    ST_DXM  = 16'h0400,
    ST_DYM  = 16'h0800,
    ST_SXM  = 16'h1000,
    ST_SYM  = 16'h2000,
    ST_RM   = 16'h4000,
    ST_FIN  = 16'h8000
  } state_t;

endpackage

FILE: design/ncp_mul.sv
module ncp_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ncp_pkg::MUL_W-1:0]     op_a,
  input  logic [ncp_pkg::MUL_W-1:0]     op_b,
  output logic                          done,
  output logic [2*ncp_pkg::MUL_W-1:0]   prod
);

  localparam int unsigned PW = ncp_pkg::MUL_W + ncp_pkg::DIGIT_W;

  logic                           busy;
  logic [ncp_pkg::MUL_CNT_W-1:0]  cnt;
  logic [ncp_pkg::MUL_W-1:0]      mcand;
  logic [PW-1:0]                  pp;

  // radix-16 shift-add: one multiplier digit per cycle, low digits fall out of prod
  always_comb begin
    pp = PW'(prod[2*ncp_pkg::MUL_W-1:ncp_pkg::MUL_W])
       + PW'(PW'(mcand) * PW'(prod[ncp_pkg::DIGIT_W-1:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ncp_pkg::MUL_CNT_W'(ncp_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= op_a;
      prod  <= {{ncp_pkg::MUL_W{1'b0}}, op_b};
    end else if (busy) begin
      prod <= {pp, prod[ncp_pkg::MUL_W-1:ncp_pkg::DIGIT_W]};
    end
  end

endmodule

FILE: design/ncp_div.sv
module ncp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ncp_pkg::NUM_W-1:0]     num,
  input  logic [ncp_pkg::MUL_W-1:0]     den,
  output logic                          done,
  output logic [ncp_pkg::DEPTH_W-1:0]   quo
);

  localparam int unsigned QW = ncp_pkg::DEPTH_W;
  localparam int unsigned DW = ncp_pkg::MUL_W;

  logic                           busy;
  logic [ncp_pkg::DIV_CNT_W-1:0]  cnt;
  logic                           sat;
  logic [DW-1:0]                  rem;
  logic [QW-1:0]                  nbits;
  logic [QW-1:0]                  q;
  logic [DW:0]                    trial;
  logic [DW:0]                    sub;
  logic                           ge;

  always_comb begin
    trial = {rem, nbits[QW-1]};
    sub   = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
  end

  assign quo = sat ? ncp_pkg::DEPTH_MAX : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ncp_pkg::DIV_CNT_W'(ncp_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle; high quotient bits only flag saturation
  always_ff @(posedge clk) begin
    if (start) begin
      sat   <= {{(DW + QW - ncp_pkg::NUM_W){1'b0}}, num} >= {den, {QW{1'b0}}};
      rem   <= DW'(num[ncp_pkg::NUM_W-1:QW]);
      nbits <= num[QW-1:0];
      q     <= '0;
    end else if (busy) begin
      rem   <= ge ? sub[DW-1:0] : trial[DW-1:0];
      q     <= {q[QW-2:0], ge};
      nbits <= {nbits[QW-2:0], 1'b0};
    end
  end

endmodule

FILE: design/nearest_ray_cylinder_pick.sv
// channel | dir | handshake              | payload
// cand    | in  | cand_valid/cand_ready  | ncp_pkg::cand_t
// pick    | out | pick_valid/pick_ready  | ncp_pkg::pick_t
// cfg     | in  | cfg_we                 | cfg_index, cfg_data
//
// One request at a time. Each request takes up to ten products on a radix-16 serial
// multiplier (seven when the ray is vertical) and up to two quotients on a
// one-bit-per-cycle divider.
// rst is synchronous; it restores the ray registers and clears the search.
// A result waits in the pick register; only a last request stalls behind it.
module nearest_ray_cylinder_pick (
  input  logic            clk,
  input  logic            rst,
  input  logic            cand_valid,
  output logic            cand_ready,
  input  ncp_pkg::cand_t  cand,
  output logic            pick_valid,
  input  logic            pick_ready,
  output ncp_pkg::pick_t  pick,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  ncp_pkg::state_t state;

  logic signed [31:0] org_x, org_y, org_z, dir_x, dir_y, dir_z;

  logic [31:0]        c_id;
  logic signed [31:0] c_bz;
  logic [30:0]        c_h;
  logic [30:0]        c_r;
  logic               c_last;
  logic signed [32:0] rox, roy;

  logic [63:0]        a_sum, m1, m2, bm;
  logic               bneg;
  logic [30:0]        t;
  logic signed [63:0] zat, dxv, dyv;
  logic [127:0]       d2;
  logic               in_reach;

  logic [31:0]        nearest_depth, nearest_id;
  logic               any_hit;

  logic               launched;
  logic               is_mul, is_div;
  logic               mul_start, mul_done, div_start, div_done;
  logic [63:0]        mul_a, mul_b;
  logic [127:0]       mul_prod;
  logic [79:0]        div_num;
  logic [63:0]        div_den;
  logic [30:0]        div_quo;

  logic [31:0]        dxm, dym, dzm;
  logic [32:0]        roxm, roym;
  logic [63:0]        dxvm, dyvm;
  logic [63:0]        a_next;
  logic               n1, n2;
  logic [64:0]        m_diff;
  logic [63:0]        bm_next;
  logic               bneg_next;
  logic signed [63:0] zp_s, zlo, zhi, oz_q, xp_s, yp_s, rox_q, roy_q;
  logic signed [32:0] bzh;
  logic signed [33:0] diff_lo, diff_hi, diff;
  logic [33:0]        diffm;
  logic               below, above;
  logic               hit_next, upd, out_load;
  logic [31:0]        nd_next, nid_next;

  assign cand_ready = (state == ncp_pkg::ST_IDLE);

  always_comb begin
    dxm  = dir_x[31] ? 32'(-dir_x) : dir_x;
    dym  = dir_y[31] ? 32'(-dir_y) : dir_y;
    dzm  = dir_z[31] ? 32'(-dir_z) : dir_z;
    roxm = rox[32] ? 33'(-rox) : rox;
    roym = roy[32] ? 33'(-roy) : roy;
    dxvm = dxv[63] ? 64'(-dxv) : dxv;
    dyvm = dyv[63] ? 64'(-dyv) : dyv;

    a_next = a_sum + mul_prod[63:0];
    n1     = rox[32] ^ dir_x[31];
    n2     = roy[32] ^ dir_y[31];
    m_diff = {1'b0, m1} - {1'b0, m2};

    if (n1 == n2) begin
      bm_next   = m1 + m2;
      bneg_next = n1;
    end else if (!m_diff[64]) begin
      bm_next   = m_diff[63:0];
      bneg_next = n1;
    end else begin
      bm_next   = 64'(-m_diff);
      bneg_next = n2;
    end

    oz_q  = {{16{org_z[31]}}, org_z, 16'b0};
    rox_q = {{15{rox[32]}}, rox, 16'b0};
    roy_q = {{15{roy[32]}}, roy, 16'b0};
    zp_s  = dir_z[31] ? 64'(-mul_prod[63:0]) : mul_prod[63:0];
    xp_s  = dir_x[31] ? 64'(-mul_prod[63:0]) : mul_prod[63:0];
    yp_s  = dir_y[31] ? 64'(-mul_prod[63:0]) : mul_prod[63:0];

    bzh     = {c_bz[31], c_bz} + {2'b0, c_h};
    zlo     = {{16{c_bz[31]}}, c_bz, 16'b0};
    zhi     = {{15{bzh[32]}}, bzh, 16'b0};
    below   = zat < zlo;
    above   = zat > zhi;
    diff_lo = {{2{c_bz[31]}}, c_bz} - {{2{org_z[31]}}, org_z};
    diff_hi = {bzh[32], bzh} - {{2{org_z[31]}}, org_z};
    diff    = below ? diff_lo : diff_hi;
    diffm   = diff[33] ? 34'(-diff) : diff;

    is_mul = state inside {ncp_pkg::ST_A1, ncp_pkg::ST_A2, ncp_pkg::ST_M1, ncp_pkg::ST_M2,
                           ncp_pkg::ST_ZM, ncp_pkg::ST_DXM, ncp_pkg::ST_DYM,
                           ncp_pkg::ST_SXM, ncp_pkg::ST_SYM, ncp_pkg::ST_RM};
    is_div = state inside {ncp_pkg::ST_DIV1, ncp_pkg::ST_ZDIV};
    mul_start = is_mul && !launched;
    div_start = is_div && !launched;

    mul_a = '0;
    mul_b = '0;
    case (state)
      ncp_pkg::ST_A1:  begin mul_a = 64'(dxm);  mul_b = 64'(dxm);  end
      ncp_pkg::ST_A2:  begin mul_a = 64'(dym);  mul_b = 64'(dym);  end
      ncp_pkg::ST_M1:  begin mul_a = 64'(roxm); mul_b = 64'(dxm);  end
      ncp_pkg::ST_M2:  begin mul_a = 64'(roym); mul_b = 64'(dym);  end
      ncp_pkg::ST_ZM:  begin mul_a = 64'(dzm);  mul_b = 64'(t);    end
      ncp_pkg::ST_DXM: begin mul_a = 64'(dxm);  mul_b = 64'(t);    end
      ncp_pkg::ST_DYM: begin mul_a = 64'(dym);  mul_b = 64'(t);    end
      ncp_pkg::ST_SXM: begin mul_a = dxvm;      mul_b = dxvm;      end
      ncp_pkg::ST_SYM: begin mul_a = dyvm;      mul_b = dyvm;      end
      ncp_pkg::ST_RM:  begin mul_a = 64'(c_r);  mul_b = 64'(c_r);  end
      default:         begin mul_a = '0;        mul_b = '0;        end
    endcase

    if (state == ncp_pkg::ST_ZDIV) begin
      div_num = 80'({diffm, 16'b0});
      div_den = 64'(dzm);
    end else begin
      div_num = {bm, 16'b0};
      div_den = a_sum;
    end

    hit_next = any_hit | in_reach;
    upd      = in_reach && ({1'b0, t} < nearest_depth);
    nd_next  = upd ? {1'b0, t} : nearest_depth;
    nid_next = upd ? c_id : nearest_id;
    out_load = (state == ncp_pkg::ST_FIN) && c_last && (!pick_valid || pick_ready);
  end

  ncp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ncp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
      dir_x <= '0;
      dir_y <= '0;
      dir_z <= 32'sh0001_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        ncp_pkg::REG_ORIGIN_X: org_x <= cfg_data;
        ncp_pkg::REG_ORIGIN_Y: org_y <= cfg_data;
        ncp_pkg::REG_ORIGIN_Z: org_z <= cfg_data;
        ncp_pkg::REG_DIR_X:    dir_x <= cfg_data;
        ncp_pkg::REG_DIR_Y:    dir_y <= cfg_data;
        ncp_pkg::REG_DIR_Z:    dir_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ncp_pkg::ST_IDLE;
      launched      <= 1'b0;
      any_hit       <= 1'b0;
      nearest_depth <= '1;
      nearest_id    <= '0;
      pick_valid    <= 1'b0;
    end else begin
      if (pick_valid && pick_ready && !out_load) begin
        pick_valid <= 1'b0;
      end
      if (mul_start || div_start) begin
        launched <= 1'b1;
      end
      if (mul_done || div_done) begin
        launched <= 1'b0;
      end
      case (state)
        ncp_pkg::ST_IDLE: begin
          if (cand_valid) begin
            state <= ncp_pkg::ST_A1;
          end
        end
        ncp_pkg::ST_A1: begin
          if (mul_done) begin
            state <= ncp_pkg::ST_A2;
          end
        end
        ncp_pkg::ST_A2: begin
          if (mul_done) begin
            state <= (a_next == '0) ? ncp_pkg::ST_DXM : ncp_pkg::ST_M1;
          end
        end
        ncp_pkg::ST_M1: begin
          if (mul_done) begin
            state <= ncp_pkg::ST_M2;
          end
        end
        ncp_pkg::ST_M2: begin
          if (mul_done) begin
            state <= ncp_pkg::ST_BM;
          end
        end
        ncp_pkg::ST_BM: begin
          state <= (bneg_next && bm_next != '0) ? ncp_pkg::ST_DIV1 : ncp_pkg::ST_ZM;
        end
        ncp_pkg::ST_DIV1: begin
          if (div_done) begin
            state <= ncp_pkg::ST_ZM;
          end
        end
        ncp_pkg::ST_ZM: begin
          if (mul_done) begin
            state <= ncp_pkg::ST_ZCMP;
          end
        end
        ncp_pkg::ST_ZCMP: begin
          if ((below || above) && dir_z != '0 && diff != '0 && (diff[33] == dir_z[31])) begin
            state <= ncp_pkg::ST_ZDIV;
          end else begin
            state <= ncp_pkg::ST_DXM;
          end
        end
        ncp_pkg::ST_ZDIV: begin
          if (div_done) begin
            state <= ncp_pkg::ST_DXM;
          end
        end
        ncp_pkg::ST_DXM: begin
          if (mul_done) begin
            state <= ncp_pkg::ST_DYM;
          end
        end
        ncp_pkg::ST_DYM: begin
          if (mul_done) begin
            state <= ncp_pkg::ST_SXM;
          end
        end
        ncp_pkg::ST_SXM: begin
          if (mul_done) begin
            state <= ncp_pkg::ST_SYM;
          end
        end
        ncp_pkg::ST_SYM: begin
          if (mul_done) begin
            state <= ncp_pkg::ST_RM;
          end
        end
        ncp_pkg::ST_RM: begin
          if (mul_done) begin
            state <= ncp_pkg::ST_FIN;
          end
        end
        ncp_pkg::ST_FIN: begin
          if (!c_last) begin
            any_hit       <= hit_next;
            nearest_depth <= nd_next;
            nearest_id    <= nid_next;
            state         <= ncp_pkg::ST_IDLE;
          end else if (out_load) begin
            pick_valid    <= 1'b1;
            any_hit       <= 1'b0;
            nearest_depth <= '1;
            nearest_id    <= '0;
            state         <= ncp_pkg::ST_IDLE;
          end
        end
        default: state <= ncp_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ncp_pkg::ST_IDLE && cand_valid) begin
      c_id   <= cand.entity_id;
      c_bz   <= cand.base_z;
      c_h    <= cand.height;
      c_r    <= (cand.sel_radius > cand.model_scale) ? cand.sel_radius : cand.model_scale;
      c_last <= cand.last_entity;
      rox    <= {org_x[31], org_x} - {cand.base_x[31], cand.base_x};
      roy    <= {org_y[31], org_y} - {cand.base_y[31], cand.base_y};
      t      <= '0;
    end
    if (mul_done) begin
      case (state)
        ncp_pkg::ST_A1:  a_sum <= mul_prod[63:0];
        ncp_pkg::ST_A2:  a_sum <= a_next;
        ncp_pkg::ST_M1:  m1    <= mul_prod[63:0];
        ncp_pkg::ST_M2:  m2    <= mul_prod[63:0];
        ncp_pkg::ST_ZM:  zat   <= oz_q + zp_s;
        ncp_pkg::ST_DXM: dxv   <= rox_q + xp_s;
        ncp_pkg::ST_DYM: dyv   <= roy_q + yp_s;
        ncp_pkg::ST_SXM: d2    <= mul_prod;
        ncp_pkg::ST_SYM: d2    <= d2 + mul_prod;
        ncp_pkg::ST_RM:  in_reach <= d2 <= {mul_prod[95:0], 32'b0};
        default: ;
      endcase
    end
    if (state == ncp_pkg::ST_BM) begin
      bm   <= bm_next;
      bneg <= bneg_next;
    end
    if (state == ncp_pkg::ST_BM && !(bneg_next && bm_next != '0)) begin
      t <= '0;
    end
    if (div_done) begin
      t <= div_quo;
    end
    if (state == ncp_pkg::ST_ZCMP && (below || above) && dir_z != '0
        && (diff == '0 || diff[33] != dir_z[31])) begin
      t <= '0;
    end
    if (out_load) begin
      pick.hit_found  <= hit_next;
      pick.best_id    <= hit_next ? nid_next : '0;
      pick.best_depth <= hit_next ? nd_next[30:0] : ncp_pkg::DEPTH_MAX;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cand_valid && cand_ready |=> state == ncp_pkg::ST_A1)
    else $error("accepted request did not start the sequence");

  a_unit_owned: assert property (@(posedge clk) disable iff (rst)
    (mul_done || div_done) |-> launched)
    else $error("arithmetic unit finished without a launch");

  a_search_cleared: assert property (@(posedge clk) disable iff (rst)
    out_load |=> !any_hit && nearest_depth == '1 && nearest_id == '0)
    else $error("search state not cleared after result");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    pick_valid && !pick.hit_found |->
      pick.best_id == '0 && pick.best_depth == ncp_pkg::DEPTH_MAX)
    else $error("miss result carries stale fields");

endmodule
